### rtl/nmea_pkg.sv
// Package for the GGA sentence field extractor: character codes, field numbers,
// digit weights and the packed result type.
// No dependencies.
package nmea_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;

  localparam int unsigned HDR_LEN = 5;

  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_FIX  = 4'd6;
  localparam logic [3:0] FLD_SAT  = 4'd7;

  localparam int unsigned IN_WIDTH  = 8;
  localparam int unsigned OUT_WIDTH = 96;

  typedef struct packed {
    logic [6:0]  pad;
    logic        satellites_valid;
    logic [6:0]  satellites;
    logic        has_fix;
    logic        lon_valid;
    logic [19:0] lon_minutes_e4;
    logic [9:0]  lon_degrees;
    logic        lat_valid;
    logic [19:0] lat_minutes_e4;
    logic [6:0]  lat_degrees;
    logic [6:0]  utc_seconds;
    logic [6:0]  utc_minutes;
    logic [6:0]  utc_hours;
  } gga_result_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    case (pos)
      3'd0:    hdr_char = 8'h47;
      3'd1:    hdr_char = 8'h50;
      3'd2:    hdr_char = 8'h47;
      3'd3:    hdr_char = 8'h47;
      3'd4:    hdr_char = 8'h41;
      default: hdr_char = 8'h00;
    endcase
  endfunction

  function automatic logic [19:0] lat_min_w(input logic [3:0] pos);
    case (pos)
      4'd2:    lat_min_w = 20'd100000;
      4'd3:    lat_min_w = 20'd10000;
      4'd5:    lat_min_w = 20'd1000;
      4'd6:    lat_min_w = 20'd100;
      4'd7:    lat_min_w = 20'd10;
      4'd8:    lat_min_w = 20'd1;
      default: lat_min_w = 20'd0;
    endcase
  endfunction

  function automatic logic [19:0] lon_min_w(input logic [3:0] pos);
    case (pos)
      4'd3:    lon_min_w = 20'd100000;
      4'd4:    lon_min_w = 20'd10000;
      4'd6:    lon_min_w = 20'd1000;
      4'd7:    lon_min_w = 20'd100;
      4'd8:    lon_min_w = 20'd10;
      4'd9:    lon_min_w = 20'd1;
      default: lon_min_w = 20'd0;
    endcase
  endfunction

endpackage

### rtl/nmea_gga_field_extractor_top.sv
// GGA sentence field extractor: parses a byte stream and emits one result per
// accepted GPGGA sentence at its line feed. Depends on nmea_pkg.
// A result is registered and valid in the cycle after the line feed transaction when
// the output register is free.
// Throughput: one byte per cycle while s_tready is high; the per-byte field accumulators set the rate.
// A two-entry output (result register plus skid register) keeps input open
// while one result waits; input stalls only when both are full.
// Reset: synchronous, active high; clears parser state and output valids.
module nmea_gga_field_extractor_top #(
  parameter int unsigned IN_W  = nmea_pkg::IN_WIDTH,
  parameter int unsigned OUT_W = nmea_pkg::OUT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // utc_hours, utc_minutes, utc_seconds,
                                      // lat_degrees, lat_minutes_e4, lat_valid,
                                      // lon_degrees, lon_minutes_e4, lon_valid,
                                      // has_fix, satellites, satellites_valid
);

  logic        in_sentence;
  logic [2:0]  header_pos;
  logic        header_match;
  logic [3:0]  field_index;
  logic [3:0]  char_in_field;
  logic [6:0]  hours_acc;
  logic [6:0]  minutes_acc;
  logic [6:0]  seconds_acc;
  logic [6:0]  lat_deg_acc;
  logic [19:0] lat_min_acc;
  logic        lat_ok;
  logic [9:0]  lon_deg_acc;
  logic [19:0] lon_min_acc;
  logic        lon_ok;
  logic        fix_seen;
  logic [6:0]  sat_acc;
  logic [1:0]  sat_digits;

  nmea_pkg::gga_result_t out_reg;
  nmea_pkg::gga_result_t skid_reg;
  nmea_pkg::gga_result_t result_new;
  logic                  out_valid;
  logic                  skid_valid;

  logic       accept;
  logic       pop;
  logic       emit;
  logic [7:0] b;
  logic       isdig;
  logic [3:0] d;
  logic [7:0] b_off;
  logic       is_lf;

  assign b        = s_tdata[7:0];
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_reg);

  assign isdig = b inside {[nmea_pkg::CH_ZERO : nmea_pkg::CH_NINE]};
  assign b_off = b - nmea_pkg::CH_ZERO;
  assign d     = isdig ? b_off[3:0] : 4'd0;
  assign is_lf = (b == nmea_pkg::CH_LF);
  assign emit  = accept && in_sentence && is_lf && header_match &&
                 (header_pos == 3'(nmea_pkg::HDR_LEN));

  always_comb begin
    result_new                  = '0;
    result_new.utc_hours        = hours_acc;
    result_new.utc_minutes      = minutes_acc;
    result_new.utc_seconds      = seconds_acc;
    result_new.lat_degrees      = lat_ok ? lat_deg_acc : 7'd0;
    result_new.lat_minutes_e4   = lat_ok ? lat_min_acc : 20'd0;
    result_new.lat_valid        = lat_ok;
    result_new.lon_degrees      = lon_ok ? lon_deg_acc : 10'd0;
    result_new.lon_minutes_e4   = lon_ok ? lon_min_acc : 20'd0;
    result_new.lon_valid        = lon_ok;
    result_new.has_fix          = fix_seen;
    result_new.satellites       = (sat_digits == 2'b11) ? sat_acc : 7'd0;
    result_new.satellites_valid = (sat_digits == 2'b11);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence   <= 1'b0;
      header_pos    <= '0;
      header_match  <= 1'b0;
      field_index   <= '0;
      char_in_field <= '0;
      hours_acc     <= '0;
      minutes_acc   <= '0;
      seconds_acc   <= '0;
      lat_deg_acc   <= '0;
      lat_min_acc   <= '0;
      lat_ok        <= 1'b0;
      lon_deg_acc   <= '0;
      lon_min_acc   <= '0;
      lon_ok        <= 1'b0;
      fix_seen      <= 1'b0;
      sat_acc       <= '0;
      sat_digits    <= '0;
    end else if (accept && b != nmea_pkg::CH_NUL) begin
      if (b == nmea_pkg::CH_START) begin
        in_sentence   <= 1'b1;
        header_pos    <= '0;
        header_match  <= 1'b1;
        field_index   <= '0;
        char_in_field <= '0;
        hours_acc     <= '0;
        minutes_acc   <= '0;
        seconds_acc   <= '0;
        lat_deg_acc   <= '0;
        lat_min_acc   <= '0;
        lat_ok        <= 1'b0;
        lon_deg_acc   <= '0;
        lon_min_acc   <= '0;
        lon_ok        <= 1'b0;
        fix_seen      <= 1'b0;
        sat_acc       <= '0;
        sat_digits    <= '0;
      end else if (in_sentence) begin
        if (is_lf) begin
          in_sentence <= 1'b0;
        end else begin
          if (header_pos < 3'(nmea_pkg::HDR_LEN)) begin
            if (b != nmea_pkg::hdr_char(header_pos)) begin
              header_match <= 1'b0;
            end
            header_pos <= header_pos + 3'd1;
          end
          if (b == nmea_pkg::CH_COMMA) begin
            if (field_index != 4'd15) begin
              field_index <= field_index + 4'd1;
            end
            char_in_field <= '0;
          end else begin
            case (field_index)
              nmea_pkg::FLD_TIME: begin
                case (char_in_field)
                  4'd0:    hours_acc   <= hours_acc + 7'(d) * 7'd10;
                  4'd1:    hours_acc   <= hours_acc + 7'(d);
                  4'd2:    minutes_acc <= minutes_acc + 7'(d) * 7'd10;
                  4'd3:    minutes_acc <= minutes_acc + 7'(d);
                  4'd4:    seconds_acc <= seconds_acc + 7'(d) * 7'd10;
                  4'd5:    seconds_acc <= seconds_acc + 7'(d);
                  default: ;
                endcase
              end
              nmea_pkg::FLD_LAT: begin
                case (char_in_field)
                  4'd0:    lat_deg_acc <= lat_deg_acc + 7'(d) * 7'd10;
                  4'd1:    lat_deg_acc <= lat_deg_acc + 7'(d);
                  default: lat_min_acc <= lat_min_acc +
                                          20'(d) * nmea_pkg::lat_min_w(char_in_field);
                endcase
                if (char_in_field == 4'd8) begin
                  lat_ok <= 1'b1;
                end
              end
              nmea_pkg::FLD_LON: begin
                case (char_in_field)
                  4'd0:    lon_deg_acc <= lon_deg_acc + 10'(d) * 10'd100;
                  4'd1:    lon_deg_acc <= lon_deg_acc + 10'(d) * 10'd10;
                  4'd2:    lon_deg_acc <= lon_deg_acc + 10'(d);
                  default: lon_min_acc <= lon_min_acc +
                                          20'(d) * nmea_pkg::lon_min_w(char_in_field);
                endcase
                if (char_in_field == 4'd9) begin
                  lon_ok <= 1'b1;
                end
              end
              nmea_pkg::FLD_FIX: begin
                if (char_in_field == 4'd0 &&
                    (b == nmea_pkg::CH_ONE || b == nmea_pkg::CH_TWO)) begin
                  fix_seen <= 1'b1;
                end
              end
              nmea_pkg::FLD_SAT: begin
                if (isdig && char_in_field == 4'd0) begin
                  sat_acc       <= sat_acc + 7'(d) * 7'd10;
                  sat_digits[0] <= 1'b1;
                end else if (isdig && char_in_field == 4'd1) begin
                  sat_acc       <= sat_acc + 7'(d);
                  sat_digits[1] <= 1'b1;
                end
              end
              default: ;
            endcase
            if (char_in_field != 4'd15) begin
              char_in_field <= char_in_field + 4'd1;
            end
          end
        end
      end
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_reg <= skid_reg;
      end
    end else if (emit) begin
      if (!out_valid || pop) begin
        out_reg <= result_new;
      end else begin
        skid_reg <= result_new;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_lf_ends_sentence: assert property (@(posedge clk) disable iff (rst)
    accept && is_lf |=> !in_sentence)
    else $error("line feed did not close the sentence");

  a_lat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reg.lat_valid |->
      out_reg.lat_degrees == 7'd0 && out_reg.lat_minutes_e4 == 20'd0)
    else $error("invalid latitude carries nonzero value");

  a_sat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reg.satellites_valid |-> out_reg.satellites == 7'd0)
    else $error("invalid satellite count carries nonzero value");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("result lost after line feed");

endmodule
